// ----- src/crr_pkg.sv -----
package crr_pkg;

  localparam int unsigned STAGES = 7;
  localparam int unsigned ENTRIES_PER_STAGE = 64;
  localparam int unsigned VALUE_BITS = 32;

  localparam int unsigned STAGE_W = (STAGES > 1) ? $clog2(STAGES) : 1;
  localparam int unsigned IDX_W = (ENTRIES_PER_STAGE > 1) ? $clog2(ENTRIES_PER_STAGE) : 1;
  localparam int unsigned CNT_W = $clog2(ENTRIES_PER_STAGE + 1);
  localparam int unsigned ADDR_W = STAGE_W + IDX_W;
  localparam int unsigned DEPTH = STAGES * (2 ** IDX_W);
  localparam int unsigned QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    KIND_LOAD    = 2'd0,
    KIND_FORWARD = 2'd1,
    KIND_REVERSE = 2'd2,
    KIND_CLEAR   = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_RANGE = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    OP_LOAD    = 2'd0,
    OP_QUERY   = 2'd1,
    OP_CLEAR   = 2'd2,
    OP_REJECT  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_READ  = 2'd1,
    ST_CHECK = 2'd2,
    ST_DONE  = 2'd3
  } state_e;

  typedef struct packed {
    logic [1:0]  kind;
    logic [2:0]  stage;
    logic [31:0] source_start;
    logic [31:0] dest_start;
    logic [31:0] span;
    logic [31:0] value;
  } in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] mapped_value;
    logic [31:0] running_minimum;
  } out_t;

  typedef struct packed {
    op_e                   op;
    logic                  reverse;
    status_e               status;
    logic [STAGE_W-1:0]    stage;
    logic [VALUE_BITS-1:0] source_start;
    logic [VALUE_BITS-1:0] dest_start;
    logic [VALUE_BITS-1:0] span;
    logic [VALUE_BITS-1:0] value;
  } cmd_t;

endpackage

// ----- src/crr_front.sv -----
module crr_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  crr_pkg::in_t  in_data_i,
  output logic          cmd_valid_o,
  input  logic          cmd_pop_i,
  output crr_pkg::cmd_t cmd_o
);

  localparam int unsigned PTR_W = $clog2(crr_pkg::QUEUE_DEPTH);

  crr_pkg::cmd_t          queue_q [crr_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]       wr_ptr_q, rd_ptr_q;
  logic [PTR_W:0]         count_q;
  crr_pkg::cmd_t          cmd_d;
  logic                   push;
  logic [crr_pkg::VALUE_BITS:0] src_end, dst_end;

  assign in_stall_o  = (count_q == (PTR_W + 1)'(crr_pkg::QUEUE_DEPTH));
  assign push        = in_valid_i && !in_stall_o;
  assign cmd_valid_o = (count_q != '0);
  assign cmd_o       = queue_q[rd_ptr_q];

  always_comb begin
    src_end = {1'b0, in_data_i.source_start[crr_pkg::VALUE_BITS-1:0]}
            + {1'b0, in_data_i.span[crr_pkg::VALUE_BITS-1:0]};
    dst_end = {1'b0, in_data_i.dest_start[crr_pkg::VALUE_BITS-1:0]}
            + {1'b0, in_data_i.span[crr_pkg::VALUE_BITS-1:0]};
    cmd_d.reverse      = (in_data_i.kind == crr_pkg::KIND_REVERSE);
    cmd_d.status       = crr_pkg::STATUS_OK;
    cmd_d.stage        = in_data_i.stage[crr_pkg::STAGE_W-1:0];
    cmd_d.source_start = in_data_i.source_start[crr_pkg::VALUE_BITS-1:0];
    cmd_d.dest_start   = in_data_i.dest_start[crr_pkg::VALUE_BITS-1:0];
    cmd_d.span         = in_data_i.span[crr_pkg::VALUE_BITS-1:0];
    cmd_d.value        = in_data_i.value[crr_pkg::VALUE_BITS-1:0];
    case (in_data_i.kind)
      crr_pkg::KIND_LOAD: begin
        if ((src_end[crr_pkg::VALUE_BITS] && src_end[crr_pkg::VALUE_BITS-1:0] != '0) ||
            (dst_end[crr_pkg::VALUE_BITS] && dst_end[crr_pkg::VALUE_BITS-1:0] != '0)) begin
          cmd_d.op     = crr_pkg::OP_REJECT;
          cmd_d.status = crr_pkg::STATUS_RANGE;
        end else if (32'(in_data_i.stage) >= crr_pkg::STAGES) begin
          cmd_d.op     = crr_pkg::OP_REJECT;
          cmd_d.status = crr_pkg::STATUS_FULL;
        end else begin
          cmd_d.op = crr_pkg::OP_LOAD;
        end
      end
      crr_pkg::KIND_FORWARD, crr_pkg::KIND_REVERSE: cmd_d.op = crr_pkg::OP_QUERY;
      default: cmd_d.op = crr_pkg::OP_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wr_ptr_q] <= cmd_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (cmd_pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      count_q <= count_q + (PTR_W + 1)'(push) - (PTR_W + 1)'(cmd_pop_i);
    end
  end

endmodule

// ----- src/crr_back.sv -----
module crr_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cmd_valid_i,
  output logic          cmd_pop_o,
  input  crr_pkg::cmd_t cmd_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output crr_pkg::out_t out_data_o
);

  localparam int unsigned VB = crr_pkg::VALUE_BITS;

  logic [VB-1:0] src_mem [crr_pkg::DEPTH];
  logic [VB-1:0] dst_mem [crr_pkg::DEPTH];
  logic [VB-1:0] span_mem [crr_pkg::DEPTH];

  crr_pkg::state_e state_q, state_d;
  logic [crr_pkg::CNT_W-1:0] count_q [crr_pkg::STAGES];
  logic [crr_pkg::CNT_W-1:0] count_d [crr_pkg::STAGES];
  logic [VB-1:0] lowest_q, lowest_d;
  logic [VB-1:0] value_q, value_d;
  logic [crr_pkg::STAGE_W-1:0] stg_q, stg_d;
  logic [crr_pkg::CNT_W-1:0] idx_q, idx_d;
  logic out_valid_q, out_valid_d;
  crr_pkg::out_t out_q, out_d;
  logic [VB-1:0] rd_src_q, rd_dst_q, rd_span_q;
  logic [crr_pkg::ADDR_W-1:0] rd_addr, wr_addr;
  logic rd_en, wr_en;
  logic [VB-1:0] from_v, to_v, diff;
  logic out_free, last_stage;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign rd_addr     = {stg_q, idx_q[crr_pkg::IDX_W-1:0]};
  assign wr_addr     = {cmd_i.stage, count_q[cmd_i.stage][crr_pkg::IDX_W-1:0]};
  assign last_stage  = cmd_i.reverse ? (stg_q == '0)
                     : (stg_q == crr_pkg::STAGE_W'(crr_pkg::STAGES - 1));

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      src_mem[wr_addr]  <= cmd_i.source_start;
      dst_mem[wr_addr]  <= cmd_i.dest_start;
      span_mem[wr_addr] <= cmd_i.span;
    end
    if (rd_en) begin
      rd_src_q  <= src_mem[rd_addr];
      rd_dst_q  <= dst_mem[rd_addr];
      rd_span_q <= span_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= crr_pkg::ST_IDLE;
      lowest_q    <= '1;
      out_valid_q <= 1'b0;
      stg_q       <= '0;
      idx_q       <= '0;
      value_q     <= '0;
      for (int i = 0; i < crr_pkg::STAGES; i++) begin
        count_q[i] <= '0;
      end
    end else begin
      state_q     <= state_d;
      lowest_q    <= lowest_d;
      out_valid_q <= out_valid_d;
      stg_q       <= stg_d;
      idx_q       <= idx_d;
      value_q     <= value_d;
      count_q     <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  always_comb begin
    state_d     = state_q;
    lowest_d    = lowest_q;
    stg_d       = stg_q;
    idx_d       = idx_q;
    value_d     = value_q;
    count_d     = count_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    cmd_pop_o   = 1'b0;
    rd_en       = 1'b0;
    wr_en       = 1'b0;
    from_v      = cmd_i.reverse ? rd_dst_q : rd_src_q;
    to_v        = cmd_i.reverse ? rd_src_q : rd_dst_q;
    diff        = value_q - from_v;
    case (state_q)
      crr_pkg::ST_IDLE: begin
        if (cmd_valid_i) begin
          case (cmd_i.op)
            crr_pkg::OP_QUERY: begin
              value_d = cmd_i.value;
              idx_d   = '0;
              stg_d   = cmd_i.reverse ? crr_pkg::STAGE_W'(crr_pkg::STAGES - 1) : '0;
              state_d = crr_pkg::ST_READ;
            end
            default: begin
              if (out_free) begin
                cmd_pop_o   = 1'b1;
                out_valid_d = 1'b1;
                out_d.mapped_value = '0;
                out_d.status       = cmd_i.status;
                if (cmd_i.op == crr_pkg::OP_CLEAR) begin
                  for (int i = 0; i < crr_pkg::STAGES; i++) begin
                    count_d[i] = '0;
                  end
                  lowest_d = '1;
                  out_d.running_minimum = 32'(VB'('1));
                end else begin
                  out_d.running_minimum = 32'(lowest_q);
                  if (cmd_i.op == crr_pkg::OP_LOAD) begin
                    if (count_q[cmd_i.stage] ==
                        crr_pkg::CNT_W'(crr_pkg::ENTRIES_PER_STAGE)) begin
                      out_d.status = crr_pkg::STATUS_FULL;
                    end else begin
                      wr_en = 1'b1;
                      count_d[cmd_i.stage] = count_q[cmd_i.stage] + 1'b1;
                    end
                  end
                end
              end
            end
          endcase
        end
      end
      crr_pkg::ST_READ: begin
        if (idx_q == count_q[stg_q]) begin
          if (last_stage) begin
            state_d = crr_pkg::ST_DONE;
          end else begin
            stg_d = cmd_i.reverse ? stg_q - 1'b1 : stg_q + 1'b1;
            idx_d = '0;
          end
        end else begin
          rd_en   = 1'b1;
          state_d = crr_pkg::ST_CHECK;
        end
      end
      crr_pkg::ST_CHECK: begin
        if (value_q >= from_v && diff < rd_span_q) begin
          value_d = to_v + diff;
          idx_d   = '0;
          if (last_stage) begin
            state_d = crr_pkg::ST_DONE;
          end else begin
            stg_d   = cmd_i.reverse ? stg_q - 1'b1 : stg_q + 1'b1;
            state_d = crr_pkg::ST_READ;
          end
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = crr_pkg::ST_READ;
        end
      end
      default: begin
        if (out_free) begin
          cmd_pop_o   = 1'b1;
          out_valid_d = 1'b1;
          out_d.status       = crr_pkg::STATUS_OK;
          out_d.mapped_value = 32'(value_q);
          if (!cmd_i.reverse && value_q < lowest_q) begin
            lowest_d = value_q;
            out_d.running_minimum = 32'(value_q);
          end else begin
            out_d.running_minimum = 32'(lowest_q);
          end
          state_d = crr_pkg::ST_IDLE;
        end
      end
    endcase
  end

endmodule

// ----- src/cascaded_range_remap.sv -----
// Seven cascaded range-remap tables of 64 entries each. A front stage classifies each
// transaction and range-checks loads; a two-entry queue decouples it from the back
// stage, which owns the entry memory. Loads, clears and rejected loads are answered
// from the idle state with a registered result. A query walks the valid entries of
// each stage in order, one memory read and one compare per entry, stopping a stage at
// its first match; a stage that ends without a match is left through the read state.
// Only entries written since the last clear are ever read, so no clearing pass
// follows reset.
module cascaded_range_remap (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  crr_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output crr_pkg::out_t out_data_o
);

  logic          cmd_valid;
  logic          cmd_pop;
  crr_pkg::cmd_t cmd;

  crr_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .cmd_valid_o (cmd_valid),
    .cmd_pop_i   (cmd_pop),
    .cmd_o       (cmd)
  );

  crr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_pop_o   (cmd_pop),
    .cmd_i       (cmd),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ----- tb/tb_cascaded_range_remap.sv -----
`timescale 1ns / 1ps

module tb_cascaded_range_remap;

  localparam int unsigned IDLE_LIMIT = 20000;
  localparam int unsigned IN_W = $bits(crr_pkg::in_t);

  logic          clk_i;
  logic          rst_ni;
  logic          in_valid_i;
  logic          in_stall_o;
  crr_pkg::in_t  in_data_i;
  logic          out_valid_o;
  logic          out_stall_i;
  crr_pkg::out_t out_data_o;

  cascaded_range_remap uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  // Shadow copy of the remap tables, used to predict each result.
  logic [31:0] map_src [crr_pkg::STAGES][crr_pkg::ENTRIES_PER_STAGE];
  logic [31:0] map_dst [crr_pkg::STAGES][crr_pkg::ENTRIES_PER_STAGE];
  logic [31:0] map_span[crr_pkg::STAGES][crr_pkg::ENTRIES_PER_STAGE];
  int unsigned map_count[crr_pkg::STAGES];
  logic [31:0] map_lowest;

  crr_pkg::in_t  pending_items[$];
  crr_pkg::out_t expected_results[$];
  int   failures;
  int   accepted_in;
  int   accepted_out;
  int   idle_cycles;
  int   n_total;
  int   n_fwd, n_rev, n_load_ok, n_full, n_range, n_clear;
  bit   calm;

  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  function automatic logic [31:0] remap_stage(int unsigned st, logic [31:0] v, bit rev);
    logic [31:0] from;
    logic [31:0] to;
    for (int i = 0; i < map_count[st]; i++) begin
      from = rev ? map_dst[st][i] : map_src[st][i];
      to   = rev ? map_src[st][i] : map_dst[st][i];
      if (v >= from && (v - from) < map_span[st][i]) begin
        return to + (v - from);
      end
    end
    return v;
  endfunction

  function automatic crr_pkg::out_t predict_remap(crr_pkg::in_t it);
    crr_pkg::out_t r;
    logic [31:0] v;
    r = '0;
    r.status = crr_pkg::STATUS_OK;
    v = it.value;
    case (crr_pkg::kind_e'(it.kind))
      crr_pkg::KIND_LOAD: begin
        if ({1'b0, it.source_start} + {1'b0, it.span} > 33'h1_0000_0000 ||
            {1'b0, it.dest_start} + {1'b0, it.span} > 33'h1_0000_0000) begin
          r.status = crr_pkg::STATUS_RANGE;
          n_range++;
        end else if (it.stage >= crr_pkg::STAGES ||
                     map_count[it.stage] >= crr_pkg::ENTRIES_PER_STAGE) begin
          r.status = crr_pkg::STATUS_FULL;
          n_full++;
        end else begin
          map_src[it.stage][map_count[it.stage]]  = it.source_start;
          map_dst[it.stage][map_count[it.stage]]  = it.dest_start;
          map_span[it.stage][map_count[it.stage]] = it.span;
          map_count[it.stage]++;
          n_load_ok++;
        end
      end
      crr_pkg::KIND_FORWARD: begin
        for (int s = 0; s < crr_pkg::STAGES; s++) begin
          v = remap_stage(s, v, 1'b0);
        end
        r.mapped_value = v;
        if (v < map_lowest) begin
          map_lowest = v;
        end
        n_fwd++;
      end
      crr_pkg::KIND_REVERSE: begin
        for (int s = crr_pkg::STAGES - 1; s >= 0; s--) begin
          v = remap_stage(s, v, 1'b1);
        end
        r.mapped_value = v;
        n_rev++;
      end
      default: begin
        for (int s = 0; s < crr_pkg::STAGES; s++) begin
          map_count[s] = 0;
        end
        map_lowest = '1;
        n_clear++;
      end
    endcase
    r.running_minimum = map_lowest;
    return r;
  endfunction

  function automatic crr_pkg::in_t make_item(crr_pkg::kind_e k, logic [2:0] st,
                                             logic [31:0] src, logic [31:0] dst,
                                             logic [31:0] sp, logic [31:0] v);
    crr_pkg::in_t it;
    it.kind = k;
    it.stage = st;
    it.source_start = src;
    it.dest_start = dst;
    it.span = sp;
    it.value = v;
    return it;
  endfunction

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 255);
      1: return 32'hFFFF_FFFF - $urandom_range(0, 255);
      default: return $urandom();
    endcase
  endfunction

  function automatic crr_pkg::in_t rand_load(logic [2:0] st);
    logic [31:0] sp;
    logic [31:0] src;
    logic [31:0] dst;
    sp  = ($urandom_range(0, 9) == 0) ? $urandom() : $urandom_range(0, 1 << $urandom_range(0, 28));
    src = $urandom();
    dst = $urandom();
    if ($urandom_range(0, 9) != 0) begin
      if (src > 32'hFFFF_FFFF - sp) src = 32'hFFFF_FFFF - sp + 1;
      if (dst > 32'hFFFF_FFFF - sp) dst = 32'hFFFF_FFFF - sp + 1;
    end
    return make_item(crr_pkg::KIND_LOAD, st, src, dst, sp, rand_word());
  endfunction

  // Edge cases, then random loads, clears and queries.
  task automatic build_stimulus();
    logic [31:0] probe;
    int n_ent;
    pending_items.push_back(make_item(crr_pkg::KIND_FORWARD, 3'd0, '1, '1, '1, 32'd0));
    pending_items.push_back(make_item(crr_pkg::KIND_FORWARD, 3'd7, 32'd0, 32'd0, 32'd0, '1));
    pending_items.push_back(make_item(crr_pkg::KIND_REVERSE, 3'd5, '0, '1, '0, 32'h8000_0000));
    pending_items.push_back(make_item(crr_pkg::KIND_LOAD, 3'd0, 32'hFFFF_FFFF, 32'd0, 32'd1,
                                      32'd0));
    pending_items.push_back(make_item(crr_pkg::KIND_LOAD, 3'd0, 32'd0, 32'hFFFF_FFFF, 32'd2,
                                      32'd0));
    pending_items.push_back(make_item(crr_pkg::KIND_LOAD, 3'd7, 32'd0, 32'd0, 32'd1, '1));
    pending_items.push_back(make_item(crr_pkg::KIND_LOAD, 3'd0, 32'd0, 32'd0, '1, '1));
    pending_items.push_back(make_item(crr_pkg::KIND_LOAD, 3'd0, 32'd0, 32'd0, 32'd0, '1));
    pending_items.push_back(make_item(crr_pkg::KIND_LOAD, 3'd1, 32'd10, 32'd100, 32'd5, '0));
    pending_items.push_back(make_item(crr_pkg::KIND_LOAD, 3'd1, 32'd12, 32'd500, 32'd5, '0));
    pending_items.push_back(make_item(crr_pkg::KIND_LOAD, 3'd6, 32'h0, 32'h1, 32'hFFFF_FFFF,
                                      '0));
    pending_items.push_back(make_item(crr_pkg::KIND_FORWARD, 3'd0, '0, '0, '0, 32'd12));
    pending_items.push_back(make_item(crr_pkg::KIND_FORWARD, 3'd0, '0, '0, '0, 32'd15));
    pending_items.push_back(make_item(crr_pkg::KIND_FORWARD, 3'd0, '0, '0, '0, 32'hFFFF_FFFF));
    pending_items.push_back(make_item(crr_pkg::KIND_REVERSE, 3'd0, '0, '0, '0, 32'd103));
    pending_items.push_back(make_item(crr_pkg::KIND_REVERSE, 3'd0, '0, '0, '0, 32'd0));
    for (int i = 0; i < crr_pkg::ENTRIES_PER_STAGE + 1; i++) begin
      pending_items.push_back(make_item(crr_pkg::KIND_LOAD, 3'd3, i * 16, i * 16 + 1, 16, '0));
    end
    pending_items.push_back(make_item(crr_pkg::KIND_FORWARD, 3'd0, '0, '0, '0, 32'd1023));
    pending_items.push_back(make_item(crr_pkg::KIND_REVERSE, 3'd0, '0, '0, '0, 32'd1024));
    pending_items.push_back(make_item(crr_pkg::KIND_CLEAR, 3'd7, '1, '1, '1, '1));
    pending_items.push_back(make_item(crr_pkg::KIND_FORWARD, 3'd0, '0, '0, '0, 32'd12));
    while (pending_items.size() < 1320) begin
      if ($urandom_range(0, 19) == 0) begin
        pending_items.push_back(make_item(crr_pkg::KIND_CLEAR, 3'($urandom()), $urandom(),
                                          $urandom(), $urandom(), $urandom()));
      end
      n_ent = $urandom_range(1, 10);
      for (int i = 0; i < n_ent; i++) begin
        pending_items.push_back(rand_load(($urandom_range(0, 19) == 0) ? 3'd7
                                          : 3'($urandom_range(0, 6))));
      end
      for (int i = 0; i < $urandom_range(2, 12); i++) begin
        probe = rand_word();
        if ($urandom_range(0, 1) == 0) probe = $urandom_range(0, 1 << 28);
        pending_items.push_back(make_item($urandom_range(0, 2) == 0 ? crr_pkg::KIND_REVERSE
                                          : crr_pkg::KIND_FORWARD, 3'($urandom()),
                                          $urandom(), $urandom(), $urandom(), probe));
      end
    end
  endtask

  // Driver.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!(in_valid_i && in_stall_o)) begin
        if (pending_items.size() > 0 && (calm || $urandom_range(0, 99) >= 11)) begin
          in_data_i  <= pending_items.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
          in_data_i  <= crr_pkg::in_t'(IN_W'({$urandom(), $urandom(), $urandom(),
                                              $urandom(), $urandom()}));
        end
      end
      out_stall_i <= !calm && ($urandom_range(0, 99) < 11);
    end
  end

  // Monitor.
  always @(posedge clk_i) begin
    crr_pkg::out_t exp_r;
    bit            progress;
    progress = 1'b0;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        expected_results.push_back(predict_remap(in_data_i));
        accepted_in++;
        progress = 1'b1;
      end
      if (out_valid_o && !out_stall_i) begin
        progress = 1'b1;
        accepted_out++;
        if (expected_results.size() == 0) begin
          $error("unexpected transaction: status %0d mapped %h minimum %h",
                 out_data_o.status, out_data_o.mapped_value, out_data_o.running_minimum);
          failures++;
        end else begin
          exp_r = expected_results.pop_front();
          if (out_data_o.status !== exp_r.status) begin
            $error("status: expected %0d, actual %0d", exp_r.status, out_data_o.status);
            failures++;
          end
          if (out_data_o.mapped_value !== exp_r.mapped_value) begin
            $error("mapped_value: expected %h, actual %h",
                   exp_r.mapped_value, out_data_o.mapped_value);
            failures++;
          end
          if (out_data_o.running_minimum !== exp_r.running_minimum) begin
            $error("running_minimum: expected %h, actual %h",
                   exp_r.running_minimum, out_data_o.running_minimum);
            failures++;
          end
        end
      end
      idle_cycles <= progress ? 0 : idle_cycles + 1;
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    out_stall_i = 1'b0;
    failures = 0;
    accepted_in = 0;
    accepted_out = 0;
    idle_cycles = 0;
    calm = 1'b0;
    for (int s = 0; s < crr_pkg::STAGES; s++) begin
      map_count[s] = 0;
    end
    map_lowest = '1;
    build_stimulus();
    n_total = pending_items.size();
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    wait (accepted_in >= 600);
    calm = 1'b1;
    wait (accepted_in >= 800);
    calm = 1'b0;
    wait (accepted_out >= n_total);
    repeat (20) @(posedge clk_i);
    $display("Covered %0d forward and %0d reverse queries, %0d stored loads, %0d clears.",
             n_fwd, n_rev, n_load_ok, n_clear);
    $display("Rejected loads: %0d table full, %0d out of range; %0d results checked.",
             n_full, n_range, accepted_out);
    if (failures == 0 && expected_results.size() == 0 && accepted_out == n_total) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
